>>> rtl/lvm_pkg.sv
package lvm_pkg;

	// Fixed-point format
	localparam int FRAC = 16;
	localparam int DW   = 32;

	// Magnitude of a difference of two words, or of one cross-product term
	localparam int MW  = DW + 1;
	// Sum of three squared magnitudes (3 * 2^64 < 2^66)
	localparam int SQW = 2 * MW;
	// Root bits, one per square-root stage
	localparam int RB  = MW;
	// Quotient bits of a normalized component (quotient never exceeds 1.0)
	localparam int QB  = FRAC + 1;
	// Dividend width: magnitude shifted up by the fraction bits
	localparam int ND  = MW + FRAC;
	// Signed normalized component
	localparam int NW  = FRAC + 2;
	// Signed right-vector component before normalization
	localparam int CW  = DW + 2;
	// Signed true-up component
	localparam int VW  = NW + 1;
	// Widths of raw products
	localparam int PW  = NW + DW;
	localparam int VPW = 2 * NW;
	localparam int WPW = VW + DW;
	// Translation sum before saturation
	localparam int SW  = DW + 4;

	localparam logic [DW-1:0] ONE = DW'(1) << FRAC;

	typedef logic signed [DW-1:0] word_t;

	typedef enum logic [1:0] {
		CFG_UP_X = 2'd0,
		CFG_UP_Y = 2'd1,
		CFG_UP_Z = 2'd2
	} cfg_idx_e;

	localparam logic [1:0] ROW_LAST = 2'd3;

	// One square-root stage plus everything that rides along
	typedef struct packed {
		logic [SQW-1:0]         rem;
		logic [RB-1:0]          root;
		logic [2:0][MW-1:0]     mag;
		logic [2:0]             neg;
		logic [2:0][DW-1:0]     eye;
		logic [2:0][NW-1:0]     fn;
		logic                   dg;
	} sq_t;

	// One divider stage, three components in parallel
	typedef struct packed {
		logic [2:0][ND-1:0]     rem;
		logic [2:0][QB-1:0]     quo;
		logic [RB-1:0]          len;
		logic [2:0]             neg;
		logic [2:0][DW-1:0]     eye;
		logic [2:0][NW-1:0]     fn;
		logic                   dg;
	} dv_t;

	// Decide root bit i: (root + 2^i)^2 - root^2 = root*2^(i+1) + 2^(2i)
	function automatic sq_t sqrt_step(input sq_t s, input int i);
		sq_t            o;
		logic [SQW:0]   t;
		o = s;
		t = ((SQW+1)'(s.root) << (i + 1)) | ((SQW+1)'(1) << (2 * i));
		if ({1'b0, s.rem} >= t) begin
			o.rem     = s.rem - t[SQW-1:0];
			o.root[i] = 1'b1;
		end
		return o;
	endfunction

	// Hand the root and the magnitudes over to the divider
	function automatic dv_t sq_to_dv(input sq_t s);
		dv_t o;
		for (int c = 0; c < 3; c++) begin
			o.rem[c] = ND'(s.mag[c]) << FRAC;
			o.quo[c] = '0;
		end
		o.len = s.root;
		o.neg = s.neg;
		o.eye = s.eye;
		o.fn  = s.fn;
		o.dg  = s.dg;
		return o;
	endfunction

	// Restoring division, quotient bit i of each component
	function automatic dv_t div_step(input dv_t d, input int i);
		dv_t            o;
		logic [ND-1:0]  dd;
		o  = d;
		dd = ND'(d.len) << i;
		for (int c = 0; c < 3; c++) begin
			if (d.rem[c] >= dd) begin
				o.rem[c]    = d.rem[c] - dd;
				o.quo[c][i] = 1'b1;
			end
		end
		return o;
	endfunction

	// Signed normalized components; zero length gives a zero vector
	function automatic logic [2:0][NW-1:0] dv_norm(input dv_t d);
		logic [2:0][NW-1:0] o;
		for (int c = 0; c < 3; c++) begin
			if (d.len == '0)
				o[c] = '0;
			else if (d.neg[c])
				o[c] = -NW'(d.quo[c]);
			else
				o[c] = NW'(d.quo[c]);
		end
		return o;
	endfunction

	function automatic word_t sat32(input logic signed [SW-1:0] v);
		if (v > SW'(signed'({1'b0, {(DW-1){1'b1}}})))
			return {1'b0, {(DW-1){1'b1}}};
		if (v < -SW'(signed'({1'b0, 1'b1, {(DW-1){1'b0}}})))
			return {1'b1, {(DW-1){1'b0}}};
		return DW'(v);
	endfunction

endpackage

>>> rtl/lvm_norm.sv
module lvm_norm (
	input  logic          clk,
	input  logic          en,
	input  lvm_pkg::sq_t  din,
	output lvm_pkg::dv_t  dout
);
	import lvm_pkg::*;

	sq_t sqrt_s [RB];
	dv_t div_s  [QB];

	// Integer square root, one root bit per stage, MSB first
	for (genvar k = 0; k < RB; k++) begin : g_sqrt
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en)
					sqrt_s[k] <= sqrt_step(din, RB - 1 - k);
			end
		end else begin : g_rest
			always_ff @(posedge clk) begin
				if (en)
					sqrt_s[k] <= sqrt_step(sqrt_s[k-1], RB - 1 - k);
			end
		end
	end

	// Component divided by length, one quotient bit per stage
	for (genvar k = 0; k < QB; k++) begin : g_div
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en)
					div_s[k] <= div_step(sq_to_dv(sqrt_s[RB-1]), QB - 1 - k);
			end
		end else begin : g_rest
			always_ff @(posedge clk) begin
				if (en)
					div_s[k] <= div_step(div_s[k-1], QB - 1 - k);
			end
		end
	end

	assign dout = div_s[QB-1];

endmodule

>>> rtl/lookat_view_matrix_core.sv
// Right-handed look-at view matrix in signed Q16.16. Each transaction on the input channel
// (eye and target points) produces four row transactions on the output channel, row 0 to 3,
// with last on row 3 and the same degenerate flag on all four. The up vector comes from the
// three config registers; the user must write them only while the block is idle, which the
// block itself does not enforce. The datapath is a 111-stage pipeline that moves as one:
// two normalize units, each a 33-stage square root followed by a 17-stage divider, plus
// product and sum stages. It accepts new input transactions while earlier ones are still in
// flight, and stalls the input only while its tail holds a result that the output buffer
// cannot yet take; the four rows leave one per cycle on the single output channel when not stalled.
module lookat_view_matrix_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_index,
	input  logic [31:0]    cfg_data,
	input  logic           in_valid,
	output logic           in_stall,
	input  lvm_pkg::word_t eye_x,
	input  lvm_pkg::word_t eye_y,
	input  lvm_pkg::word_t eye_z,
	input  lvm_pkg::word_t target_x,
	input  lvm_pkg::word_t target_y,
	input  lvm_pkg::word_t target_z,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [1:0]     row_index,
	output lvm_pkg::word_t elem0,
	output lvm_pkg::word_t elem1,
	output lvm_pkg::word_t elem2,
	output lvm_pkg::word_t elem3,
	output logic           degenerate,
	output logic           last
);
	import lvm_pkg::*;

	localparam int DEPTH = 3 + (RB + QB) + 4 + (RB + QB) + 4;

	logic adv;
	logic load;

	// ---------------- config registers ----------------
	word_t up_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q[0] <= '0;
			up_q[1] <= ONE;
			up_q[2] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_UP_X: up_q[0] <= cfg_data;
				CFG_UP_Y: up_q[1] <= cfg_data;
				CFG_UP_Z: up_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- valid chain ----------------
	logic [DEPTH:1] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (adv)
			vld_q <= {vld_q[DEPTH-1:1], in_valid};
	end

	assign in_stall = !adv;

	// ---------------- s1: forward difference ----------------
	logic [2:0][MW-1:0] fd_s1;
	logic [2:0][DW-1:0] eye_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			fd_s1[0]  <= MW'(target_x) - MW'(eye_x);
			fd_s1[1]  <= MW'(target_y) - MW'(eye_y);
			fd_s1[2]  <= MW'(target_z) - MW'(eye_z);
			eye_s1[0] <= eye_x;
			eye_s1[1] <= eye_y;
			eye_s1[2] <= eye_z;
		end
	end

	// ---------------- s2: magnitudes and squares ----------------
	logic [2:0][SQW-1:0] sqr_s2;
	logic [2:0][MW-1:0]  mag_s2;
	logic [2:0]          neg_s2;
	logic [2:0][DW-1:0]  eye_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) begin
				logic [MW-1:0] m;
				m = fd_s1[c][MW-1] ? -fd_s1[c] : fd_s1[c];
				mag_s2[c] <= m;
				neg_s2[c] <= fd_s1[c][MW-1];
				sqr_s2[c] <= SQW'(m) * SQW'(m);
			end
			eye_s2 <= eye_s1;
		end
	end

	// ---------------- s3: squared length ----------------
	sq_t fsq_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			fsq_s3.rem  <= sqr_s2[0] + sqr_s2[1] + sqr_s2[2];
			fsq_s3.root <= '0;
			fsq_s3.mag  <= mag_s2;
			fsq_s3.neg  <= neg_s2;
			fsq_s3.eye  <= eye_s2;
			fsq_s3.fn   <= '0;
			fsq_s3.dg   <= 1'b0;
		end
	end

	// ---------------- normalize forward ----------------
	dv_t fdv;

	lvm_norm u_norm_f (
		.clk  (clk),
		.en   (adv),
		.din  (fsq_s3),
		.dout (fdv)
	);

	// ---------------- s4: cross products f x up ----------------
	logic signed [PW-1:0] rp_s4 [6];
	logic [2:0][NW-1:0]   fn_s4;
	logic                 dg_s4;
	logic [2:0][DW-1:0]   eye_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			logic [2:0][NW-1:0] f;
			f = dv_norm(fdv);
			rp_s4[0] <= signed'(f[1]) * up_q[2];
			rp_s4[1] <= signed'(f[2]) * up_q[1];
			rp_s4[2] <= signed'(f[2]) * up_q[0];
			rp_s4[3] <= signed'(f[0]) * up_q[2];
			rp_s4[4] <= signed'(f[0]) * up_q[1];
			rp_s4[5] <= signed'(f[1]) * up_q[0];
			fn_s4    <= f;
			dg_s4    <= (fdv.len == '0);
			eye_s4   <= fdv.eye;
		end
	end

	// ---------------- s5: right vector ----------------
	logic [2:0][CW-1:0] r_s5;
	logic [2:0][NW-1:0] fn_s5;
	logic               dg_s5;
	logic [2:0][DW-1:0] eye_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++)
				r_s5[c] <= CW'(rp_s4[2*c] >>> FRAC) - CW'(rp_s4[2*c+1] >>> FRAC);
			fn_s5  <= fn_s4;
			dg_s5  <= dg_s4;
			eye_s5 <= eye_s4;
		end
	end

	// ---------------- s6: magnitudes and squares ----------------
	logic [2:0][SQW-1:0] sqr_s6;
	logic [2:0][MW-1:0]  mag_s6;
	logic [2:0]          neg_s6;
	logic [2:0][NW-1:0]  fn_s6;
	logic                dg_s6;
	logic [2:0][DW-1:0]  eye_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) begin
				logic [CW-1:0] a;
				a = r_s5[c][CW-1] ? -r_s5[c] : r_s5[c];
				mag_s6[c] <= a[MW-1:0];
				neg_s6[c] <= r_s5[c][CW-1];
				sqr_s6[c] <= SQW'(a[MW-1:0]) * SQW'(a[MW-1:0]);
			end
			fn_s6  <= fn_s5;
			dg_s6  <= dg_s5;
			eye_s6 <= eye_s5;
		end
	end

	// ---------------- s7: squared length ----------------
	sq_t rsq_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			rsq_s7.rem  <= sqr_s6[0] + sqr_s6[1] + sqr_s6[2];
			rsq_s7.root <= '0;
			rsq_s7.mag  <= mag_s6;
			rsq_s7.neg  <= neg_s6;
			rsq_s7.eye  <= eye_s6;
			rsq_s7.fn   <= fn_s6;
			rsq_s7.dg   <= dg_s6;
		end
	end

	// ---------------- normalize right ----------------
	dv_t rdv;

	lvm_norm u_norm_r (
		.clk  (clk),
		.en   (adv),
		.din  (rsq_s7),
		.dout (rdv)
	);

	// ---------------- s8: r x f products, r.e and f.e products ----------------
	logic signed [VPW-1:0] vp_s8 [6];
	logic signed [PW-1:0]  re_s8 [3];
	logic signed [PW-1:0]  fe_s8 [3];
	logic [2:0][NW-1:0]    rn_s8;
	logic [2:0][NW-1:0]    fn_s8;
	logic                  dg_s8;
	logic [2:0][DW-1:0]    eye_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			logic [2:0][NW-1:0] r;
			r = dv_norm(rdv);
			vp_s8[0] <= signed'(r[1]) * signed'(rdv.fn[2]);
			vp_s8[1] <= signed'(r[2]) * signed'(rdv.fn[1]);
			vp_s8[2] <= signed'(r[2]) * signed'(rdv.fn[0]);
			vp_s8[3] <= signed'(r[0]) * signed'(rdv.fn[2]);
			vp_s8[4] <= signed'(r[0]) * signed'(rdv.fn[1]);
			vp_s8[5] <= signed'(r[1]) * signed'(rdv.fn[0]);
			for (int c = 0; c < 3; c++) begin
				re_s8[c] <= signed'(r[c]) * signed'(rdv.eye[c]);
				fe_s8[c] <= signed'(rdv.fn[c]) * signed'(rdv.eye[c]);
			end
			rn_s8  <= r;
			fn_s8  <= rdv.fn;
			dg_s8  <= rdv.dg | (rdv.len == '0);
			eye_s8 <= rdv.eye;
		end
	end

	// ---------------- s9: true up, translation x and z ----------------
	logic [2:0][VW-1:0] v_s9;
	word_t              tx_s9;
	word_t              tz_s9;
	logic [2:0][NW-1:0] rn_s9;
	logic [2:0][NW-1:0] fn_s9;
	logic               dg_s9;
	logic [2:0][DW-1:0] eye_s9;

	always_ff @(posedge clk) begin
		if (adv) begin
			logic signed [SW-1:0] sr;
			logic signed [SW-1:0] sf;
			sr = SW'(re_s8[0] >>> FRAC) + SW'(re_s8[1] >>> FRAC) + SW'(re_s8[2] >>> FRAC);
			sf = SW'(fe_s8[0] >>> FRAC) + SW'(fe_s8[1] >>> FRAC) + SW'(fe_s8[2] >>> FRAC);
			for (int c = 0; c < 3; c++)
				v_s9[c] <= VW'(vp_s8[2*c] >>> FRAC) - VW'(vp_s8[2*c+1] >>> FRAC);
			tx_s9  <= sat32(-sr);
			tz_s9  <= sat32(sf);
			rn_s9  <= rn_s8;
			fn_s9  <= fn_s8;
			dg_s9  <= dg_s8;
			eye_s9 <= eye_s8;
		end
	end

	// ---------------- s10: v.e products ----------------
	logic signed [WPW-1:0] ve_s10 [3];
	logic [2:0][VW-1:0]    v_s10;
	word_t                 tx_s10;
	word_t                 tz_s10;
	logic [2:0][NW-1:0]    rn_s10;
	logic [2:0][NW-1:0]    fn_s10;
	logic                  dg_s10;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++)
				ve_s10[c] <= signed'(v_s9[c]) * signed'(eye_s9[c]);
			v_s10  <= v_s9;
			tx_s10 <= tx_s9;
			tz_s10 <= tz_s9;
			rn_s10 <= rn_s9;
			fn_s10 <= fn_s9;
			dg_s10 <= dg_s9;
		end
	end

	// ---------------- s11: translation y ----------------
	word_t              ty_s11;
	word_t              tx_s11;
	word_t              tz_s11;
	logic [2:0][VW-1:0] v_s11;
	logic [2:0][NW-1:0] rn_s11;
	logic [2:0][NW-1:0] fn_s11;
	logic               dg_s11;

	always_ff @(posedge clk) begin
		if (adv) begin
			logic signed [SW-1:0] sv;
			sv = SW'(ve_s10[0] >>> FRAC) + SW'(ve_s10[1] >>> FRAC)
			   + SW'(ve_s10[2] >>> FRAC);
			ty_s11 <= sat32(-sv);
			tx_s11 <= tx_s10;
			tz_s11 <= tz_s10;
			v_s11  <= v_s10;
			rn_s11 <= rn_s10;
			fn_s11 <= fn_s10;
			dg_s11 <= dg_s10;
		end
	end

	// ---------------- output buffer and row sequencer ----------------
	logic               out_valid_q;
	logic [1:0]         row_q;
	logic [2:0][NW-1:0] rn_q;
	logic [2:0][NW-1:0] fn_q;
	logic [2:0][VW-1:0] v_q;
	word_t              tx_q;
	word_t              ty_q;
	word_t              tz_q;
	logic               dg_q;

	// pipeline moves when its tail is empty or hands off into the buffer
	assign load = vld_q[DEPTH] && (!out_valid_q || (!out_stall && row_q == ROW_LAST));
	assign adv  = !vld_q[DEPTH] || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			row_q       <= '0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			row_q       <= '0;
		end else if (out_valid_q && !out_stall) begin
			if (row_q == ROW_LAST)
				out_valid_q <= 1'b0;
			else
				row_q <= row_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rn_q <= rn_s11;
			fn_q <= fn_s11;
			v_q  <= v_s11;
			tx_q <= tx_s11;
			ty_q <= ty_s11;
			tz_q <= tz_s11;
			dg_q <= dg_s11;
		end
	end

	// Row select
	always_comb begin
		case (row_q)
			ROW_LAST: begin
				elem0 = tx_q;
				elem1 = ty_q;
				elem2 = tz_q;
				elem3 = ONE;
			end
			default: begin
				elem0 = DW'(signed'(rn_q[row_q]));
				elem1 = DW'(signed'(v_q[row_q]));
				elem2 = -DW'(signed'(fn_q[row_q]));
				elem3 = '0;
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign row_index  = row_q;
	assign degenerate = dg_q;
	assign last       = (row_q == ROW_LAST);

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import lvm_pkg::*;

	// One matrix row as it leaves the block
	typedef struct {
		logic [1:0]  idx;
		logic [31:0] e [4];
		logic        dg;
		logic        lst;
	} row_t;

	// Golden look-at math, bit exact, plus the queue of rows still owed
	class view_scoreboard;
		row_t rows [$];
		int   errors;

		function automatic longint absv(longint v);
			return v < 0 ? -v : v;
		endfunction

		// floor(sqrt(x^2 + y^2 + z^2))
		function automatic longint length3(longint x, longint y, longint z);
			logic [71:0] n, c, res;
			n = 72'(absv(x)) * 72'(absv(x)) + 72'(absv(y)) * 72'(absv(y))
				+ 72'(absv(z)) * 72'(absv(z));
			res = '0;
			for (int i = 35; i >= 0; i--) begin
				c = res | (72'(1) << i);
				if (c * c <= n)
					res = c;
			end
			return longint'(res);
		endfunction

		function automatic longint unit_comp(longint v, longint len);
			longint q;
			if (len == 0)
				return 0;
			q = (absv(v) << FRAC) / len;
			return v < 0 ? -q : q;
		endfunction

		// floored fixed-point product
		function automatic longint fxmul(longint a, longint b);
			longint p;
			p = a * b;
			return p >>> FRAC;
		endfunction

		function automatic longint clamp32(longint v);
			if (v > 64'sd2147483647)
				return 64'sd2147483647;
			if (v < -64'sd2147483648)
				return -64'sd2147483648;
			return v;
		endfunction

		function void note(word_t eye [3], word_t tgt [3], word_t up [3]);
			longint ex, ey, ez, ux, uy, uz, fx, fy, fz, rx, ry, rz, vx, vy, vz, fl, rl;
			longint m [16];
			row_t   r;
			ex = eye[0]; ey = eye[1]; ez = eye[2];
			ux = up[0]; uy = up[1]; uz = up[2];
			fx = longint'(tgt[0]) - ex;
			fy = longint'(tgt[1]) - ey;
			fz = longint'(tgt[2]) - ez;
			fl = length3(fx, fy, fz);
			fx = unit_comp(fx, fl); fy = unit_comp(fy, fl); fz = unit_comp(fz, fl);
			rx = fxmul(fy, uz) - fxmul(fz, uy);
			ry = fxmul(fz, ux) - fxmul(fx, uz);
			rz = fxmul(fx, uy) - fxmul(fy, ux);
			rl = length3(rx, ry, rz);
			rx = unit_comp(rx, rl); ry = unit_comp(ry, rl); rz = unit_comp(rz, rl);
			vx = fxmul(ry, fz) - fxmul(rz, fy);
			vy = fxmul(rz, fx) - fxmul(rx, fz);
			vz = fxmul(rx, fy) - fxmul(ry, fx);
			m[0] = rx; m[1] = vx; m[2]  = -fx; m[3]  = 0;
			m[4] = ry; m[5] = vy; m[6]  = -fy; m[7]  = 0;
			m[8] = rz; m[9] = vz; m[10] = -fz; m[11] = 0;
			m[12] = clamp32(-(fxmul(rx, ex) + fxmul(ry, ey) + fxmul(rz, ez)));
			m[13] = clamp32(-(fxmul(vx, ex) + fxmul(vy, ey) + fxmul(vz, ez)));
			m[14] = clamp32(fxmul(fx, ex) + fxmul(fy, ey) + fxmul(fz, ez));
			m[15] = longint'(1) << FRAC;
			for (int k = 0; k < 4; k++) begin
				r.idx = 2'(k);
				for (int j = 0; j < 4; j++)
					r.e[j] = 32'(m[k*4+j]);
				r.dg  = (fl == 0) || (rl == 0);
				r.lst = (k == 3);
				rows.push_back(r);
			end
		endfunction

		function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
			if (exp_v !== act_v) begin
				$error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check(row_t got);
			row_t want;
			if (rows.size() == 0) begin
				$error("row transaction with nothing expected (row %0d)", got.idx);
				errors++;
				return;
			end
			want = rows.pop_front();
			cmp("row_index", 32'(want.idx), 32'(got.idx));
			cmp("elem0", want.e[0], got.e[0]);
			cmp("elem1", want.e[1], got.e[1]);
			cmp("elem2", want.e[2], got.e[2]);
			cmp("elem3", want.e[3], got.e[3]);
			cmp("degenerate", 32'(want.dg), 32'(got.dg));
			cmp("last", 32'(want.lst), 32'(got.lst));
		endfunction
	endclass

	logic        clk, arst_n;
	logic        cfg_we;
	cfg_idx_e    cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid, in_stall, out_valid, out_stall;
	word_t       eye_x, eye_y, eye_z, target_x, target_y, target_z;
	logic [1:0]  row_index;
	word_t       elem0, elem1, elem2, elem3;
	logic        degenerate, last;

	view_scoreboard sb;
	word_t up_reg [3];
	int    send_idle_pct, recv_stall_pct;
	int    hold_left;

	lookat_view_matrix_core u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.eye_x(eye_x), .eye_y(eye_y), .eye_z(eye_z),
		.target_x(target_x), .target_y(target_y), .target_z(target_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.row_index(row_index), .elem0(elem0), .elem1(elem1), .elem2(elem2), .elem3(elem3),
		.degenerate(degenerate), .last(last)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("FAILURE");
		$finish;
	end

	// Output side: check each row transaction, then pick next cycle's stall
	always @(posedge clk) begin
		row_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.idx = row_index;
			got.e[0] = elem0; got.e[1] = elem1; got.e[2] = elem2; got.e[3] = elem3;
			got.dg = degenerate;
			got.lst = last;
			sb.check(got);
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// One write, then the config port is held idle before the task returns
	task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		up_reg[idx] = val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Block must be drained before the up vector changes
	task automatic drain();
		while (sb.rows.size() != 0)
			@(posedge clk);
		repeat (130) @(posedge clk);
	endtask

	task automatic send_point(word_t e [3], word_t t [3]);
		eye_x <= e[0]; eye_y <= e[1]; eye_z <= e[2];
		target_x <= t[0]; target_y <= t[1]; target_z <= t[2];
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		sb.note(e, t, up_reg);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	function automatic word_t pick_edge();
		case ($urandom_range(0, 4))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return 32'h0001_0000;
		endcase
	endfunction

	task automatic send_random();
		word_t e [3], t [3];
		int kind;
		kind = $urandom_range(0, 9);
		for (int c = 0; c < 3; c++) begin
			case (kind)
				0, 1, 2, 3: begin
					e[c] = $urandom; t[c] = $urandom;
				end
				4, 5, 6: begin
					e[c] = $signed($urandom_range(0, 32'h1f_ffff)) - 32'sh10_0000;
					t[c] = e[c] + $signed($urandom_range(0, 32'h3_ffff)) - 32'sh2_0000;
				end
				7: begin
					e[c] = $urandom; t[c] = e[c];
				end
				8: begin
					e[c] = $urandom_range(0, 32'hff_ffff); t[c] = e[c] + up_reg[c];
				end
				default: begin
					e[c] = pick_edge(); t[c] = pick_edge();
				end
			endcase
		end
		send_point(e, t);
	endtask

	task automatic run_phase(word_t ux, word_t uy, word_t uz, int idle, int stall, int n);
		drain();
		write_reg(CFG_UP_X, ux);
		write_reg(CFG_UP_Y, uy);
		write_reg(CFG_UP_Z, uz);
		send_idle_pct  = idle;
		recv_stall_pct = stall;
		repeat (n) send_random();
		in_valid <= 1'b0;
	endtask

	initial begin
		word_t e [3], t [3];
		sb = new();
		arst_n = 0;
		cfg_we = 0; cfg_index = CFG_UP_X; cfg_data = '0;
		in_valid = 0; out_stall = 0; hold_left = 0;
		eye_x = '0; eye_y = '0; eye_z = '0;
		target_x = '0; target_y = '0; target_z = '0;
		up_reg[0] = 0; up_reg[1] = 32'h0001_0000; up_reg[2] = 0;
		send_idle_pct = 0; recv_stall_pct = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset up vector, plain views, degenerate cases, extremes
		e = '{0, 0, 0};              t = '{0, 0, -32'sh10000};  send_point(e, t);
		e = '{32'sh50000, 32'sh20000, 32'sh30000}; t = '{0, 0, 0}; send_point(e, t);
		e = '{5, 6, 7};              t = '{5, 6, 7};            send_point(e, t);
		e = '{0, 0, 0};              t = '{0, 0, 0};            send_point(e, t);
		e = '{0, 0, 0};              t = '{0, 32'sh30000, 0};   send_point(e, t);
		e = '{0, -32'sh40000, 0};    t = '{0, 32'sh10000, 0};   send_point(e, t);
		e = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
		t = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};     send_point(e, t);
		e = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
		t = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};     send_point(e, t);
		e = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
		t = '{32'h8000_0000, 32'h7fff_ffff, 0};                  send_point(e, t);
		e = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
		t = '{0, 0, 32'h7fff_ffff};                              send_point(e, t);
		e = '{1, 0, 0};              t = '{0, 1, 0};            send_point(e, t);
		e = '{32'h7fff_ffff, 0, 0};  t = '{32'h7fff_ffff, 0, 1}; send_point(e, t);
		in_valid <= 1'b0;

		// Random phases over several up vectors and idle and stall patterns
		run_phase(0, 32'sh10000, 0, 0, 0, 30);
		run_phase(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 68, 0, 25);
		run_phase(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 68, 25);
		run_phase(0, 0, 0, 12, 12, 20);
		run_phase(32'h7fff_ffff, 32'h8000_0000, 1, 12, 12, 20);
		run_phase($urandom, $urandom, $urandom, 68, 68, 20);

		// Long output hold while inputs keep coming, so the block backs up:
		// the first batch reaches the tail and freezes the pipe, the second
		// batch then sees the input stalled
		drain();
		write_reg(CFG_UP_X, 32'sh8000);
		write_reg(CFG_UP_Y, 32'sh10000);
		write_reg(CFG_UP_Z, -32'sh4000);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_left = 400;
		repeat (20) send_random();
		in_valid <= 1'b0;
		repeat (120) @(posedge clk);
		repeat (20) send_random();
		in_valid <= 1'b0;

		drain();
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> sim.f
rtl/lvm_pkg.sv
rtl/lvm_norm.sv
rtl/lookat_view_matrix_core.sv
test/testbench.sv
